@@ design/kmpsm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the streaming pattern matcher.
// Used by the cells, top level, port checker and the dv files; depends on nothing.

package kmpsm_pkg;

  // Default sizes, handed to the top level as parameter defaults.
  localparam int MAX_PAT_DEF   = 8;
  localparam int POS_WIDTH_DEF = 16;

  // Fixed field widths.
  localparam int TEXT_W     = 8;
  localparam int CFG_DATA_W = 64;
  localparam int LEN_W      = 4;
  localparam int CFG_IDX_W  = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_BYTES  = 2'd0,
    REG_PATTERN_LENGTH = 2'd1
  } cfg_reg_t;

  // Control shared by every cell of the row.
  typedef struct packed {
    logic step;   // a text item is taken this cycle
    logic clear;  // forget all partial matches
  } cell_ctrl_t;

endpackage

@@ design/kmpsm_cell.sv @@
`timescale 1ns / 1ps
// One cell of the matcher row: compares the text item with one pattern character.
// Depends on kmpsm_pkg for the cell control struct and the character width.

module kmpsm_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  kmpsm_pkg::cell_ctrl_t         ctrl,
  input  logic [kmpsm_pkg::TEXT_W-1:0]  text_byte,
  input  logic [kmpsm_pkg::TEXT_W-1:0]  pat_char,
  input  logic                          prev_match,
  output logic                          match_nxt,
  output logic                          match_r
);

  // The prefix up to this character matches if the shorter prefix matched
  // one item ago and this character matches the current item.
  assign match_nxt = prev_match && (text_byte == pat_char);

  // Partial match flag, handed to the next cell on the following item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (ctrl.clear) begin
      match_r <= 1'b0;
    end else if (ctrl.step) begin
      match_r <= match_nxt;
    end
  end

endmodule

@@ design/kmp_stream_matcher_core.sv @@
`timescale 1ns / 1ps
// Top level of the streaming pattern matcher: configuration, cell row and result register.
// Depends on kmpsm_pkg and kmpsm_cell.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------------
//   in_     | in        | in_valid/in_stall  | in_text_byte, in_end_of_text
//   out_    | out       | out_valid/out_stall| out_found, out_match_start, out_last_of_text
//   cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One item is taken per cycle while in_stall is low; its result is in the output register
// on the next cycle. The cell row sets the rate: it compares and shifts match flags at once.
// in_stall rises only while a result waits in the output register and out_stall is high.
// Reset is synchronous: pattern all zero, length one, no partial matches, position zero.
// A write to either known register clears all partial matches and keeps the text position.

module kmp_stream_matcher_core #(
  parameter int MAX_PAT   = kmpsm_pkg::MAX_PAT_DEF,
  parameter int POS_WIDTH = kmpsm_pkg::POS_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [kmpsm_pkg::TEXT_W-1:0]      in_text_byte,
  input  logic                              in_end_of_text,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_found,
  output logic [POS_WIDTH-1:0]              out_match_start,
  output logic                              out_last_of_text,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [kmpsm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [kmpsm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int IDX_W = (MAX_PAT > 1) ? $clog2(MAX_PAT) : 1;

  logic [MAX_PAT-1:0][kmpsm_pkg::TEXT_W-1:0] pat_r;
  logic [kmpsm_pkg::LEN_W-1:0]               len_r;
  logic [kmpsm_pkg::LEN_W-1:0]               len_wr;
  logic [POS_WIDTH-1:0]                      pos_r;
  logic [POS_WIDTH-1:0]                      pos_nxt;
  logic                                      out_valid_r;
  logic                                      found_r;
  logic [POS_WIDTH-1:0]                      start_r;
  logic                                      last_r;
  logic                                      accept;
  logic                                      cfg_wr;
  logic                                      cfg_known;
  logic                                      found_nxt;
  logic [POS_WIDTH-1:0]                      start_nxt;
  logic [kmpsm_pkg::LEN_W-1:0]               len_m1;
  logic [MAX_PAT-1:0]                        match_nxt;
  logic [MAX_PAT-1:0]                        match_r;
  kmpsm_pkg::cell_ctrl_t                     ctrl;

  // Handshakes.
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;

  // Only the two listed registers take effect; other indexes are ignored.
  assign cfg_known = (cfg_index == kmpsm_pkg::REG_PATTERN_BYTES) ||
                     (cfg_index == kmpsm_pkg::REG_PATTERN_LENGTH);

  // Length as it is used: zero reads as one, anything above the row size as the row size.
  always_comb begin
    if (cfg_data[kmpsm_pkg::LEN_W-1:0] == '0) begin
      len_wr = kmpsm_pkg::LEN_W'(1);
    end else if (cfg_data[kmpsm_pkg::LEN_W-1:0] > kmpsm_pkg::LEN_W'(MAX_PAT)) begin
      len_wr = kmpsm_pkg::LEN_W'(MAX_PAT);
    end else begin
      len_wr = cfg_data[kmpsm_pkg::LEN_W-1:0];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r <= '0;
      len_r <= kmpsm_pkg::LEN_W'(1);
    end else if (cfg_wr) begin
      if (cfg_index == kmpsm_pkg::REG_PATTERN_BYTES) begin
        for (int i = 0; i < MAX_PAT; i++) begin
          pat_r[i] <= cfg_data[kmpsm_pkg::TEXT_W*i +: kmpsm_pkg::TEXT_W];
        end
      end else if (cfg_index == kmpsm_pkg::REG_PATTERN_LENGTH) begin
        len_r <= len_wr;
      end
    end
  end

  // Cell control: an end-of-text item or a write to a known register forgets partial matches.
  assign ctrl.step  = accept;
  assign ctrl.clear = (cfg_wr && cfg_known) || (accept && in_end_of_text);

  // Row of cells; cell i flags that the last i+1 items equal the first i+1 characters.
  for (genvar g = 0; g < MAX_PAT; g++) begin : g_cell
    kmpsm_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .text_byte  (in_text_byte),
      .pat_char   (pat_r[g]),
      .prev_match ((g == 0) ? 1'b1 : match_r[(g == 0) ? 0 : g - 1]),
      .match_nxt  (match_nxt[g]),
      .match_r    (match_r[g])
    );
  end

  // A full match ends here when the cell for the last pattern character fires.
  assign len_m1    = len_r - kmpsm_pkg::LEN_W'(1);
  assign found_nxt = match_nxt[len_m1[IDX_W-1:0]];
  assign start_nxt = found_nxt ?
                     (pos_r - POS_WIDTH'(len_m1)) : '0;

  // Text position of the next item, back to zero after the end of a text.
  assign pos_nxt = in_end_of_text ? '0 : pos_r + POS_WIDTH'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (accept) begin
      pos_r <= pos_nxt;
    end
  end

  // Output register: loads on every taken item, empties when the result is taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      found_r <= found_nxt;
      start_r <= start_nxt;
      last_r  <= in_end_of_text;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = found_r;
  assign out_match_start  = start_r;
  assign out_last_of_text = last_r;

endmodule

@@ design/kmpsm_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the streaming pattern matcher, bound to the top level.
// Depends on kmpsm_pkg for field widths and on kmp_stream_matcher_core for the bind.

module kmpsm_checker #(
  parameter int POS_WIDTH = kmpsm_pkg::POS_WIDTH_DEF
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         in_end_of_text,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic                         out_found,
  input logic [POS_WIDTH-1:0]         out_match_start,
  input logic                         out_last_of_text
);

  // A result without a match carries a zero start position.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_match_start == '0))
    else $error("match_start not zero on a result without a match");

  // Every taken item shows its result, with its end-of-text mark, on the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (out_valid && (out_last_of_text == $past(in_end_of_text))))
    else $error("result of a taken item missing or end-of-text mark lost");

  // The input is held back only while a result waits on a stalled output.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a waiting result");

  // A stalled result stays put.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_found) && $stable(out_match_start)))
    else $error("stalled result changed");

endmodule

bind kmp_stream_matcher_core kmpsm_checker #(.POS_WIDTH(POS_WIDTH)) u_kmpsm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_end_of_text   (in_end_of_text),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_found        (out_found),
  .out_match_start  (out_match_start),
  .out_last_of_text (out_last_of_text)
);

@@ dv/kmpsm_match_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the streaming pattern matcher: watches the text, result and register channels,
// predicts every result from its own copy of the matcher state and compares field by field.
// Depends on kmpsm_pkg.

module kmpsm_match_checker
  import kmpsm_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [TEXT_W-1:0]            in_text_byte,
  input  logic                         in_end_of_text,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic                         out_found,
  input  logic [POS_WIDTH_DEF-1:0]     out_match_start,
  input  logic                         out_last_of_text,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic                         stim_done,
  output int                           fail_count,
  output int                           pending,
  output int                           found_seen
);

  localparam int MAX_PAT = MAX_PAT_DEF;
  localparam int POS_W   = POS_WIDTH_DEF;
  localparam int MAX_LINES = 50;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] start;
    logic             last;
  } match_result_t;

  // Shadow copy of the matcher's registers and state.
  logic [CFG_DATA_W-1:0] pat_bytes;
  logic [LEN_W-1:0]      pat_len_reg;
  logic [2:0]            border [MAX_PAT];
  logic [3:0]            run_len;
  logic [POS_W-1:0]      next_pos;

  match_result_t expected_q[$];
  int            fails = 0;
  int            waiting = 0;
  int            founds = 0;
  int            results_checked = 0;
  bit            leftovers_checked = 1'b0;

  assign fail_count = fails;
  assign pending    = waiting;
  assign found_seen = founds;

  task automatic report_mismatch(input string what);
    fails++;
    if (fails <= MAX_LINES) $display("[%0t] matcher mismatch: %s", $realtime, what);
  endtask

  // Length in use: zero counts as one, anything past the row size as the full row.
  function automatic int unsigned used_len();
    if (pat_len_reg == '0) return 1;
    if (pat_len_reg > MAX_PAT) return MAX_PAT;
    return pat_len_reg;
  endfunction

  function automatic logic [7:0] pat_char(input int unsigned i);
    return pat_bytes[8 * (i % 8) +: 8];
  endfunction

  // Rebuild the longest-border table and forget any partial match.
  function automatic void rebuild_borders();
    int unsigned n;
    int unsigned i;
    logic [3:0]  k;
    n = used_len();
    k = '0;
    for (i = 0; i < MAX_PAT; i++) border[i] = '0;
    for (i = 1; i < n; i++) begin
      while (k > 0 && pat_char(i) != pat_char(k)) k = border[k - 1];
      if (pat_char(i) == pat_char(k)) k++;
      border[i] = k[2:0];
    end
    run_len = '0;
  endfunction

  function automatic void reset_shadow();
    pat_bytes   = '0;
    pat_len_reg = LEN_W'(1);
    next_pos    = '0;
    rebuild_borders();
  endfunction

  // A write to an unknown index leaves everything as it was.
  function automatic void apply_reg_write(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
    if (idx == REG_PATTERN_BYTES) begin
      pat_bytes = data;
    end else if (idx == REG_PATTERN_LENGTH) begin
      pat_len_reg = data[LEN_W-1:0];
    end else begin
      return;
    end
    rebuild_borders();
  endfunction

  // Advance the matcher by one text byte and work out the result it gives.
  function automatic match_result_t predict_byte(input logic [7:0] c, input logic last);
    int unsigned   n;
    logic [3:0]    j;
    match_result_t r;
    n = used_len();
    j = run_len;
    r = '0;
    if (j >= n) j = '0;
    while (j > 0 && pat_char(j) != c) j = border[j - 1];
    if (pat_char(j) == c) j++;
    if (j == n) begin
      r.found = 1'b1;
      r.start = next_pos - POS_W'(n - 1);
      j = border[n - 1];
    end
    run_len  = j;
    next_pos = next_pos + 1'b1;
    if (last) begin
      run_len  = '0;
      next_pos = '0;
    end
    r.last = last;
    return r;
  endfunction

  // Sample all three channels at each edge; results are taken before new text items.
  always @(posedge clk) begin
    match_result_t want;
    if (!rst_n) begin
      reset_shadow();
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result found=%b start=%0d with no item outstanding",
                                    out_found, out_match_start));
        end else begin
          want = expected_q.pop_front();
          if (out_found !== want.found)
            report_mismatch($sformatf("result %0d: found %b, want %b",
                                      results_checked, out_found, want.found));
          if (out_match_start !== want.start)
            report_mismatch($sformatf("result %0d: match_start %0d, want %0d",
                                      results_checked, out_match_start, want.start));
          if (out_last_of_text !== want.last)
            report_mismatch($sformatf("result %0d: last_of_text %b, want %b",
                                      results_checked, out_last_of_text, want.last));
          if (out_found === 1'b1) founds++;
          results_checked++;
        end
      end
      if (cfg_valid && cfg_ready) apply_reg_write(cfg_index, cfg_data);
      if (in_valid && !in_stall) expected_q.push_back(predict_byte(in_text_byte, in_end_of_text));
      if (stim_done && !leftovers_checked) begin
        leftovers_checked = 1'b1;
        if (expected_q.size() != 0)
          report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
      end
    end
    waiting = expected_q.size();
  end

endmodule

@@ dv/kmp_stream_matcher_core_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the streaming pattern matcher: clock, reset, text and register stimulus,
// random back-pressure and the final verdict. Uses kmpsm_pkg, the core and kmpsm_match_checker.

module kmp_stream_matcher_core_tb;
  import kmpsm_pkg::*;

  localparam int POS_W        = POS_WIDTH_DEF;
  localparam int RANDOM_ITEMS = 1600;

  // Indexes that map to no register; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [TEXT_W-1:0]     in_text_byte = '0;
  logic                  in_end_of_text = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_found;
  logic [POS_W-1:0]      out_match_start;
  logic                  out_last_of_text;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  stim_done = 1'b0;

  int fail_count;
  int pending;
  int found_seen;

  // Stimulus bookkeeping: the pattern as last written, for building text around it.
  bit          steady = 1'b0;
  logic [7:0]  pat_chars [8];
  logic [7:0]  alpha0;
  logic [7:0]  alpha1;
  int unsigned pat_used = 1;
  int unsigned items_sent = 0;
  int unsigned reg_writes = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  kmp_stream_matcher_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_text_byte     (in_text_byte),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_found        (out_found),
    .out_match_start  (out_match_start),
    .out_last_of_text (out_last_of_text),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  kmpsm_match_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_text_byte     (in_text_byte),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_found        (out_found),
    .out_match_start  (out_match_start),
    .out_last_of_text (out_last_of_text),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .stim_done        (stim_done),
    .fail_count       (fail_count),
    .pending          (pending),
    .found_seen       (found_seen)
  );

  // Result back-pressure: roughly seven stalls in a hundred, none while steady.
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 7);
  end

  // Offer one text item, possibly after a one-cycle random gap, and wait until it is taken.
  task automatic send_item(input logic [7:0] b, input logic last);
    if (!steady && $urandom_range(0, 99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_text_byte   <= b;
    in_end_of_text <= last;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // Stop sending and wait, with a bound, until every expected result has arrived.
  task automatic settle();
    int guard;
    guard = 0;
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      guard++;
    end while (pending != 0 && guard < 5000);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  task automatic write_length(input logic [LEN_W-1:0] len_code);
    write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(len_code));
    if (len_code == '0) pat_used = 1;
    else if (len_code > 8) pat_used = 8;
    else pat_used = len_code;
  endtask

  task automatic write_pattern();
    logic [CFG_DATA_W-1:0] packed_pat;
    int i;
    for (i = 0; i < 8; i++) packed_pat[8 * i +: 8] = pat_chars[i];
    write_reg(REG_PATTERN_BYTES, packed_pat);
  endtask

  function automatic logic [7:0] pick_alpha();
    return $urandom_range(0, 1) ? alpha1 : alpha0;
  endfunction

  // New pattern characters from one of several shapes that make borders interesting.
  task automatic draw_pattern_chars();
    int unsigned shape;
    int unsigned period;
    int i;
    alpha0 = 8'($urandom);
    alpha1 = 8'($urandom);
    shape  = $urandom_range(0, 3);
    period = $urandom_range(1, 3);
    for (i = 0; i < 8; i++) begin
      case (shape)
        0: pat_chars[i] = pick_alpha();
        1: pat_chars[i] = alpha0;
        2: pat_chars[i] = (i < period) ? pick_alpha() : pat_chars[i - period];
        default: pat_chars[i] = 8'($urandom);
      endcase
    end
  endtask

  // Pick a register setting for the next phase and write it while the block is idle.
  task automatic new_random_setting(input bit force_both);
    int unsigned which;
    int unsigned r;
    logic [LEN_W-1:0] len_code;
    which = force_both ? 0 : $urandom_range(0, 9);
    r = $urandom_range(0, 99);
    if (r < 5) len_code = '0;
    else if (r < 15) len_code = LEN_W'($urandom_range(9, 15));
    else len_code = LEN_W'($urandom_range(1, 8));
    if (which < 8) begin
      draw_pattern_chars();
      write_pattern();
    end
    if (which < 6 || which >= 8) write_length(len_code);
    if ($urandom_range(0, 99) < 15)
      write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3, {$urandom, $urandom});
  endtask

  // One stretch of text: a whole or partial copy of the pattern, one of its characters, or noise.
  task automatic send_text_run();
    int unsigned r;
    int unsigned cnt;
    int unsigned k;
    r = $urandom_range(0, 99);
    if (r < 45) begin
      cnt = ($urandom_range(0, 3) == 0) ? $urandom_range(1, pat_used) : pat_used;
      for (k = 0; k < cnt; k++) send_item(pat_chars[k], $urandom_range(0, 99) < 3);
    end else if (r < 85) begin
      send_item(pat_chars[$urandom_range(0, pat_used - 1)], $urandom_range(0, 99) < 3);
    end else begin
      send_item(8'($urandom), $urandom_range(0, 99) < 3);
    end
  endtask

  initial begin
    int unsigned phase;
    int unsigned phase_len;
    int unsigned phase_start;
    int unsigned random_start;
    int unsigned k;
    bit          paused;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset pattern is a single zero byte: zeros match, all-ones does not.
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);

    // All-ones pattern with an over-range length: overlapping matches of eight.
    settle();
    write_reg(REG_PATTERN_BYTES, '1);
    write_length(LEN_W'(15));
    for (k = 0; k < 9; k++) send_item(8'hFF, k == 8);

    // Length zero acts as one.
    settle();
    write_length('0);
    send_item(8'hFF, 1'b0);
    send_item(8'h7F, 1'b1);

    // Two-character pattern; a spare-index write in mid-match must keep the partial match.
    settle();
    write_reg(REG_PATTERN_BYTES, CFG_DATA_W'(16'h6261));
    write_length(LEN_W'(2));
    send_item(8'h61, 1'b0);
    settle();
    write_reg(REG_SPARE_3, {$urandom, $urandom});
    send_item(8'h62, 1'b0);

    // A real write in mid-match clears the partial match but keeps the position.
    send_item(8'h61, 1'b0);
    settle();
    write_length(LEN_W'(2));
    send_item(8'h62, 1'b0);
    send_item(8'h61, 1'b0);
    send_item(8'h62, 1'b1);

    // Random phases, each under a fresh register setting.
    phase = 0;
    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      settle();
      new_random_setting(phase == 0);
      steady = (phase == 2);
      phase_len = steady ? 300 : $urandom_range(60, 200);
      phase_start = items_sent;
      paused = 1'b0;
      while (items_sent - phase_start < phase_len) begin
        // Hold off once mid-phase until every result is home.
        if (phase == 0 && !paused && items_sent - phase_start >= phase_len / 2) begin
          settle();
          paused = 1'b1;
        end
        send_text_run();
      end
      steady = 1'b0;
      phase++;
    end

    // Close the last text.
    send_item(8'($urandom), 1'b1);

    settle();
    repeat (10) @(posedge clk);
    stim_done <= 1'b1;
    repeat (3) @(posedge clk);

    $display("Run covered %0d text items and %0d register writes over %0d random phases.",
             items_sent, reg_writes, phase);
    $display("The block reported %0d matches, with zero, over-range and spare-index writes.",
             found_seen);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
design/kmpsm_pkg.sv
design/kmpsm_cell.sv
design/kmp_stream_matcher_core.sv
design/kmpsm_checker.sv
dv/kmpsm_match_checker.sv
dv/kmp_stream_matcher_core_tb.sv
